>>> rtl/core/bir_pkg.sv
// Package for the bilinear resize core: sizes, command and register codes,
// and the sample memory request type. No dependencies.
package bir_pkg;

  localparam int MAX_DIM     = 256;
  localparam int AW          = 8;             // log2(MAX_DIM)
  localparam int ADDR_W      = 2 * AW;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 12;
  localparam int POS_W       = 12;
  localparam int SIZE_W      = 13;
  localparam int DIM_W       = 9;
  localparam int SCALE_W     = 13;
  localparam int QUO_W       = 32;
  localparam int SCALE_MAX   = 4096;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_INTERP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SOURCE_ROWS   = 2'd0,
    REG_SOURCE_COLS   = 2'd1,
    REG_SCALE_FACTOR  = 2'd2,
    REG_ALIGN_CORNERS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                          we;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/core/bir_ifs.sv
// Channel interfaces of the bilinear resize core: input, result and config.
// Depends on bir_pkg.
interface bir_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [bir_pkg::POS_W-1:0]              row_index;
  logic [bir_pkg::POS_W-1:0]              col_index;
  logic signed [bir_pkg::SAMPLE_BITS-1:0] sample_value;
  modport source (output valid, command, row_index, col_index, sample_value, input ready);
  modport sink (input valid, command, row_index, col_index, sample_value, output ready);
endinterface

interface bir_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bir_pkg::SAMPLE_BITS-1:0] pixel_value;
  logic [bir_pkg::SIZE_W-1:0]             output_rows;
  logic [bir_pkg::SIZE_W-1:0]             output_cols;
  logic                                   in_range;
  modport source (output valid, pixel_value, output_rows, output_cols, in_range,
                  input ready);
  modport sink (input valid, pixel_value, output_rows, output_cols, in_range,
                output ready);
endinterface

interface bir_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    reg_index;
  logic [bir_pkg::SCALE_W-1:0]   write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

>>> rtl/core/bilinear_image_resize_core.sv
// Bilinear resize core. A load beat goes straight to S_DONE after accept; an
// interpolate beat runs the 32-step serial divider (both axes divide together),
// then four reads of the single-port sample memory and six multiply steps, and
// then waits in S_DONE. In S_DONE the result is registered once the output
// register is free. One beat is in work at a time; the next is taken while a
// result waits in the output register.
// Synchronous active-low reset clears control and config; the sample memory is
// undefined until loaded.
module bilinear_image_resize_core (
  input logic       clk,
  input logic       rst_n,
  bir_in_if.sink    in_ch,
  bir_out_if.source out_ch,
  bir_cfg_if.sink   cfg_ch
);
  import bir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MAP, S_RD0, S_RD1, S_RD2, S_RD3,
    S_MAC4, S_MAC5, S_MAC6, S_DONE
  } state_t;

  localparam logic [FRAC_BITS:0] ONE = 13'(1 << FRAC_BITS);

  state_t state_r;
  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [SCALE_W-1:0] scale_r;
  logic               align_r;
  logic [DIM_W-1:0]   nr, nc;
  logic [SCALE_W-1:0] s_eff;
  logic [SIZE_W-1:0]  orows_r, ocols_r;
  logic               cmd_r;
  logic [POS_W-1:0]   row_r, col_r;
  logic [AW-1:0]      ylo_r, yhi_r, xlo_r, xhi_r;
  logic [FRAC_BITS-1:0] fy_r, fx_r;
  logic [27:0]        p_r, top_r, bot_r;
  logic [40:0]        p2_r, acc_r;
  logic               out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_pix_r;
  logic [SIZE_W-1:0]  out_rows_r, out_cols_r;
  logic               out_inr_r;

  logic               accept, slot_free, div_start;
  logic [QUO_W-1:0]   y_num, x_num, y_quo, x_quo;
  logic               y_done, x_done;
  mem_req_t           mreq;
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] rb;
  logic [FRAC_BITS:0] wfx_lo, wfy_lo;
  logic [40:0]        rnd;

  // ---- configuration ----
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(MAX_DIM);
      cols_r  <= DIM_W'(MAX_DIM);
      scale_r <= SCALE_W'(256);
      align_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.reg_index))
        REG_SOURCE_ROWS:   rows_r  <= cfg_ch.write_data[DIM_W-1:0];
        REG_SOURCE_COLS:   cols_r  <= cfg_ch.write_data[DIM_W-1:0];
        REG_SCALE_FACTOR:  scale_r <= cfg_ch.write_data;
        REG_ALIGN_CORNERS: align_r <= cfg_ch.write_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [SIZE_W-1:0] out_size(input logic [DIM_W-1:0] n,
                                                 input logic [SCALE_W-1:0] s,
                                                 input logic al);
    logic [DIM_W-1:0]         m;
    logic [DIM_W+SCALE_W-1:0] p;
    m = al ? n - DIM_W'(1) : n;
    p = m * s + (al ? '0 : (DIM_W+SCALE_W)'(128));
    return SIZE_W'(p >> 8) + SIZE_W'(al);
  endfunction

  assign nr    = clamp_dim(rows_r);
  assign nc    = clamp_dim(cols_r);
  assign s_eff = (scale_r == '0) ? SCALE_W'(1) :
                 (scale_r > SCALE_W'(SCALE_MAX)) ? SCALE_W'(SCALE_MAX) : scale_r;

  // sizes are registered from the config; used only at the result stage
  always_ff @(posedge clk) begin
    orows_r <= out_size(nr, s_eff, align_r);
    ocols_r <= out_size(nc, s_eff, align_r);
  end

  // ---- coordinate divide ----
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign div_start    = accept && (in_ch.command == CMD_INTERP);
  assign y_num = align_r ? {in_ch.row_index, (8+FRAC_BITS)'(0)}
                         : {in_ch.row_index, 1'b1, (7+FRAC_BITS)'(0)};
  assign x_num = align_r ? {in_ch.col_index, (8+FRAC_BITS)'(0)}
                         : {in_ch.col_index, 1'b1, (7+FRAC_BITS)'(0)};

  bir_div u_div_y (.clk, .rst_n, .start(div_start), .num(y_num), .den(s_eff),
                   .done(y_done), .quo(y_quo));
  bir_div u_div_x (.clk, .rst_n, .start(div_start), .num(x_num), .den(s_eff),
                   .done(x_done), .quo(x_quo));

  typedef struct packed {
    logic [AW-1:0]        lo;
    logic [AW-1:0]        hi;
    logic [FRAC_BITS-1:0] fr;
  } axis_t;

  function automatic axis_t axis_map(input logic [QUO_W-1:0] q,
                                     input logic [DIM_W-1:0] n,
                                     input logic al);
    logic [QUO_W-1:0] cu;
    logic [AW-1:0]    last;
    axis_t            a;
    // negative coordinate clamps to zero
    if (!al && q < QUO_W'(1 << (FRAC_BITS-1))) cu = '0;
    else cu = al ? q : q - QUO_W'(1 << (FRAC_BITS-1));
    last = AW'(n - DIM_W'(1));
    a.lo = (cu[QUO_W-1:FRAC_BITS] > (QUO_W-FRAC_BITS)'(last)) ? last
           : cu[FRAC_BITS+AW-1:FRAC_BITS];
    a.hi = (a.lo == last) ? last : a.lo + AW'(1);
    a.fr = (a.lo == a.hi) ? '0 : cu[FRAC_BITS-1:0];
    return a;
  endfunction

  // ---- sample memory ----
  always_comb begin
    mreq.we    = 1'b0;
    mreq.addr  = {ylo_r, xlo_r};
    mreq.wdata = in_ch.sample_value;
    case (state_r)
      S_IDLE: begin
        mreq.addr = {in_ch.row_index[AW-1:0], in_ch.col_index[AW-1:0]};
        mreq.we   = accept && (in_ch.command == CMD_LOAD) &&
                    (in_ch.row_index < POS_W'(MAX_DIM)) &&
                    (in_ch.col_index < POS_W'(MAX_DIM));
      end
      S_RD1:   mreq.addr = {ylo_r, xhi_r};
      S_RD2:   mreq.addr = {yhi_r, xlo_r};
      S_RD3:   mreq.addr = {yhi_r, xhi_r};
      default: mreq.addr = {ylo_r, xlo_r};
    endcase
  end

  bir_store u_store (.clk, .req(mreq), .rdata(rdata));

  // sample offset by half range, as unsigned
  assign rb     = {~rdata[SAMPLE_BITS-1], rdata[SAMPLE_BITS-2:0]};
  assign wfx_lo = ONE - {1'b0, fx_r};
  assign wfy_lo = ONE - {1'b0, fy_r};
  assign rnd    = acc_r + 41'(1 << (2*FRAC_BITS-1));

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          cmd_r   <= in_ch.command;
          row_r   <= in_ch.row_index;
          col_r   <= in_ch.col_index;
          state_r <= (in_ch.command == CMD_INTERP) ? S_DIV : S_DONE;
        end
        S_DIV: if (y_done && x_done) state_r <= S_MAP;
        S_MAP: begin
          {ylo_r, yhi_r, fy_r} <= axis_map(y_quo, nr, align_r);
          {xlo_r, xhi_r, fx_r} <= axis_map(x_quo, nc, align_r);
          state_r <= S_RD0;
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          p_r     <= 28'(rb * wfx_lo);
          state_r <= S_RD2;
        end
        S_RD2: begin
          top_r   <= p_r + 28'(rb * fx_r);
          state_r <= S_RD3;
        end
        S_RD3: begin
          p_r     <= 28'(rb * wfx_lo);
          state_r <= S_MAC4;
        end
        S_MAC4: begin
          bot_r   <= p_r + 28'(rb * fx_r);
          state_r <= S_MAC5;
        end
        S_MAC5: begin
          p2_r    <= 41'(top_r * wfy_lo);
          state_r <= S_MAC6;
        end
        S_MAC6: begin
          acc_r   <= p2_r + 41'(bot_r * fy_r);
          state_r <= S_DONE;
        end
        S_DONE: if (slot_free) begin
          out_valid_r <= 1'b1;
          out_rows_r  <= orows_r;
          out_cols_r  <= ocols_r;
          if (cmd_r == CMD_INTERP) begin
            out_pix_r <= {~rnd[2*FRAC_BITS+SAMPLE_BITS-1],
                          rnd[2*FRAC_BITS+SAMPLE_BITS-2:2*FRAC_BITS]};
            out_inr_r <= ({1'b0, row_r} < orows_r) && ({1'b0, col_r} < ocols_r);
          end else begin
            out_pix_r <= '0;
            out_inr_r <= (row_r < POS_W'(nr)) && (col_r < POS_W'(nc));
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_value = out_pix_r;
  assign out_ch.output_rows = out_rows_r;
  assign out_ch.output_cols = out_cols_r;
  assign out_ch.in_range    = out_inr_r;
endmodule

>>> rtl/core/bir_div.sv
// Restoring divider, one quotient bit per cycle, for the source coordinate.
// Depends on bir_pkg.
module bir_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bir_pkg::QUO_W-1:0]    num,
  input  logic [bir_pkg::SCALE_W-1:0]  den,
  output logic                         done,
  output logic [bir_pkg::QUO_W-1:0]    quo
);
  import bir_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [4:0]           cnt_r;
  logic [QUO_W-1:0]     num_r;
  logic [SCALE_W-1:0]   den_r;
  logic [SCALE_W-1:0]   rem_r;
  logic [SCALE_W:0]     trial;
  logic                 qbit;

  assign trial = {rem_r, num_r[QUO_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the numerator register from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? SCALE_W'(trial - {1'b0, den_r}) : trial[SCALE_W-1:0];
      num_r <= {num_r[QUO_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule

>>> rtl/core/bir_store.sv
// Single-port sample memory, registered read, read-first.
// Depends on bir_pkg.
module bir_store (
  input  logic                                   clk,
  input  bir_pkg::mem_req_t                      req,
  output logic signed [bir_pkg::SAMPLE_BITS-1:0] rdata
);
  import bir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_DIM*MAX_DIM];
  logic signed [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;
endmodule
